// ----- design/ckl_pkg.sv -----
// Shared types and constants for the compacting key and level table.
// Used by ckl_cell and compacting_key_level_table_top; depends on nothing else.
package ckl_pkg;

   localparam int TABLE_DEPTH_DEF = 8;
   localparam int KEY_W           = 16;
   localparam int LEVEL_W         = 16;
   localparam int SLOT_W          = 3;
   localparam int ACTION_W        = 2;
   localparam int COUNT_W         = 4;
   localparam int COUNT_MAX       = 15;

   localparam logic [KEY_W-1:0] EMPTY_KEY_RESET = 16'hFFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD     = 2'd0,
      ACT_REPLACE = 2'd1,
      ACT_REMOVE  = 2'd2,
      ACT_LOOKUP  = 2'd3
   } ckl_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC
   } ckl_state_type;

   // Operation broadcast to every cell.
   typedef struct packed {
      ckl_action_type      action;
      logic [KEY_W-1:0]    key;
      logic [LEVEL_W-1:0]  level;
      logic [SLOT_W-1:0]   slot;
      logic                refused;
   } ckl_op_type;

   // Prefix flags that ripple from the low cell toward the high cell.
   typedef struct packed {
      logic add_seen;
      logic hit_seen;
      logic run;
      logic full_run;
   } ckl_link_type;

   // Contents that a cell hands to its lower neighbor.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic               empty;
   } ckl_nbr_type;

   // Per-cell status collected by the top level.
   typedef struct packed {
      logic sel;
      logic first_new_empty;
   } ckl_stat_type;

endpackage

// ----- design/ckl_cell.sv -----
// One slot of the table: key and level storage, compare flags and the update rule.
// Depends on ckl_pkg for the operation, link, neighbor and status types.
module ckl_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           exec_en,
   input  logic [ckl_pkg::KEY_W-1:0]      empty_key,
   input  ckl_pkg::ckl_op_type            op,
   input  ckl_pkg::ckl_nbr_type           nbr_in,
   input  ckl_pkg::ckl_link_type          link_in,
   output ckl_pkg::ckl_link_type          link_out,
   output ckl_pkg::ckl_nbr_type           nbr_out,
   output ckl_pkg::ckl_stat_type          stat
);

   logic [ckl_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [ckl_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                        empty_ff, empty_in;
   logic                        match_ff, match_in;
   logic                        slot_hit;
   logic                        active;
   logic                        first_add;
   logic                        first_hit;
   logic                        in_run;
   logic                        new_empty;
   logic                        sel;

   assign empty_in = (key_ff == empty_key);
   assign match_in = (key_ff == op.key);
   assign slot_hit = (CELL_INDEX < (1 << ckl_pkg::SLOT_W))
                     && (op.slot == ckl_pkg::SLOT_W'(CELL_INDEX));

   always_ff @(posedge clock) begin
      empty_ff <= empty_in;
      match_ff <= match_in;
   end

   always_comb begin
      active    = !op.refused;
      first_add = active && !link_in.add_seen && (empty_ff || match_ff);
      first_hit = active && !link_in.hit_seen && match_ff;
      in_run    = first_hit || link_in.run;
      sel       = 1'b0;
      key_in    = key_ff;
      level_in  = level_ff;
      new_empty = empty_ff;
      case (op.action)
         ckl_pkg::ACT_ADD: begin
            sel = first_add;
            if (first_add) begin
               key_in    = op.key;
               level_in  = op.level;
               new_empty = 1'b0;
            end
         end
         ckl_pkg::ACT_REPLACE: begin
            sel = active && slot_hit && !empty_ff;
            if (sel) begin
               key_in    = op.key;
               level_in  = op.level;
               new_empty = 1'b0;
            end
         end
         ckl_pkg::ACT_REMOVE: begin
            sel = first_hit;
            if (in_run) begin
               new_empty = nbr_in.empty;
               if (nbr_in.empty) begin
                  key_in   = empty_key;
                  level_in = '0;
               end else begin
                  key_in   = nbr_in.key;
                  level_in = nbr_in.level;
               end
            end
         end
         ckl_pkg::ACT_LOOKUP: begin
            sel = first_hit;
         end
         default: begin
            sel = 1'b0;
         end
      endcase
   end

   always_comb begin
      link_out.add_seen    = link_in.add_seen || empty_ff || match_ff;
      link_out.hit_seen    = link_in.hit_seen || match_ff;
      link_out.run         = in_run && !nbr_in.empty;
      link_out.full_run    = link_in.full_run && !new_empty;
      stat.sel             = sel;
      stat.first_new_empty = link_in.full_run && new_empty;
      nbr_out.key          = key_ff;
      nbr_out.level        = level_ff;
      nbr_out.empty        = empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= ckl_pkg::EMPTY_KEY_RESET;
         level_ff <= '0;
      end else if (exec_en) begin
         key_ff   <= key_in;
         level_ff <= level_in;
      end
   end

endmodule

// ----- design/compacting_key_level_table_top.sv -----
// Top level of the compacting key and level table: control, row of cells, result register.
// Depends on ckl_pkg and instantiates ckl_cell once per table slot.
//
// Usage: an item on the req_ channel carries an action (add, replace, remove,
// lookup), a key, a level and a slot. Each accepted item yields exactly one item
// on the rsp_ channel with ok, the found level, the slot touched and the count of
// leading occupied entries after the operation. Both channels use valid/ready.
// The csr_ channel writes the empty-key register and is always ready; it should
// only be written while no item is in flight.
// Flow: an accepted item is loaded into the operation register, the compare state
// registers the key compares of every cell, and the update state applies the update
// and loads the result register. A new item is taken in the same cycle that the
// previous one completes, so only one item is in flight at a time.
// The ripple of prefix flags along the row of cells runs in the update state,
// after the compare flags are registered.
// When the receiver stalls, the finished result is held in the output register.
// The item behind it finishes its compare and then waits in the update cycle,
// and req_ready stays low until the output register frees up.
// Reset is synchronous: every slot gets the reset empty key and level zero, the
// empty-key register returns to its reset value and no result is pending.
module compacting_key_level_table_top #(
   parameter int TABLE_DEPTH = ckl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ckl_pkg::ACTION_W-1:0]      req_action,
   input  logic [ckl_pkg::KEY_W-1:0]         req_key,
   input  logic [ckl_pkg::LEVEL_W-1:0]       req_level,
   input  logic [ckl_pkg::SLOT_W-1:0]        req_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [ckl_pkg::LEVEL_W-1:0]       rsp_level_out,
   output logic [ckl_pkg::SLOT_W-1:0]        rsp_slot_out,
   output logic [ckl_pkg::COUNT_W-1:0]       rsp_entry_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ckl_pkg::KEY_W-1:0]         csr_empty_key
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   ckl_pkg::ckl_state_type          state_ff, state_in;
   ckl_pkg::ckl_op_type             op_ff, op_in;
   logic [ckl_pkg::KEY_W-1:0]       empty_key_ff;
   logic                            exec_fire;
   logic                            req_fire;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [ckl_pkg::LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic [ckl_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [ckl_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   ckl_pkg::ckl_link_type           cell_link [TABLE_DEPTH+1];
   ckl_pkg::ckl_nbr_type            cell_nbr  [TABLE_DEPTH+1];
   ckl_pkg::ckl_stat_type           cell_stat [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]          sel_vec;
   logic [TABLE_DEPTH-1:0]          fne_vec;

   logic                            any_sel;
   logic                            any_empty;
   logic [CNT_W-1:0]                sel_idx;
   logic [CNT_W-1:0]                empty_idx;
   logic [CNT_W-1:0]                count;
   logic [ckl_pkg::LEVEL_W-1:0]     found_level;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_key_ff <= ckl_pkg::EMPTY_KEY_RESET;
      end else if (csr_valid) begin
         empty_key_ff <= csr_empty_key;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ckl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ckl_pkg::ST_CMP;
            end
         end
         ckl_pkg::ST_CMP: begin
            state_in = ckl_pkg::ST_EXEC;
         end
         ckl_pkg::ST_EXEC: begin
            if (exec_fire) begin
               state_in = req_valid ? ckl_pkg::ST_CMP : ckl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ckl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      exec_fire = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ckl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ckl_pkg::ST_CMP: begin
            req_ready = 1'b0;
         end
         ckl_pkg::ST_EXEC: begin
            exec_fire = !rsp_valid_ff || rsp_ready;
            req_ready = exec_fire;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ckl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      op_in = op_ff;
      if (req_fire) begin
         op_in.action  = ckl_pkg::ckl_action_type'(req_action);
         op_in.key     = req_key;
         op_in.level   = req_level;
         op_in.slot    = req_slot;
         op_in.refused = (req_key == empty_key_ff);
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign cell_link[0]           = '{add_seen: 1'b0, hit_seen: 1'b0, run: 1'b0,
                                     full_run: 1'b1};
   assign cell_nbr[TABLE_DEPTH]  = '{key: empty_key_ff, level: '0, empty: 1'b1};

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ckl_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .exec_en   (exec_fire),
         .empty_key (empty_key_ff),
         .op        (op_ff),
         .nbr_in    (cell_nbr[g+1]),
         .link_in   (cell_link[g]),
         .link_out  (cell_link[g+1]),
         .nbr_out   (cell_nbr[g]),
         .stat      (cell_stat[g])
      );
      assign sel_vec[g] = cell_stat[g].sel;
      assign fne_vec[g] = cell_stat[g].first_new_empty;
   end

   always_comb begin
      any_sel     = 1'b0;
      any_empty   = 1'b0;
      sel_idx     = '0;
      empty_idx   = '0;
      found_level = '0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         if (sel_vec[j]) begin
            any_sel     = 1'b1;
            sel_idx     = sel_idx | CNT_W'(j);
            found_level = found_level | cell_nbr[j].level;
         end
         if (fne_vec[j]) begin
            any_empty = 1'b1;
            empty_idx = empty_idx | CNT_W'(j);
         end
      end
      count = any_empty ? empty_idx : CNT_W'(TABLE_DEPTH);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_level_in = rsp_level_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = any_sel;
         rsp_level_in = (any_sel && op_ff.action == ckl_pkg::ACT_LOOKUP) ? found_level : '0;
         rsp_slot_in  = ckl_pkg::SLOT_W'(sel_idx);
         if (int'(count) > ckl_pkg::COUNT_MAX) begin
            rsp_count_in = ckl_pkg::COUNT_W'(ckl_pkg::COUNT_MAX);
         end else begin
            rsp_count_in = ckl_pkg::COUNT_W'(count);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_level_ff <= rsp_level_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_level_out   = rsp_level_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_cmp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ckl_pkg::ST_CMP)
      else $error("Accepted item did not enter the compare cycle.");

   a_single_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff == ckl_pkg::ST_EXEC |-> $onehot0(sel_vec))
      else $error("More than one cell selected by one operation.");

   a_single_boundary: assert property (@(posedge clock) disable iff (reset)
      state_ff == ckl_pkg::ST_EXEC |-> $onehot0(fne_vec))
      else $error("More than one end of the occupied run found.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff && rsp_entry_count <= ckl_pkg::COUNT_W'(ckl_pkg::COUNT_MAX))
      else $error("Completed item did not reach the result register.");
`endif

endmodule
